>>> design/q4bd_pkg.sv
package q4bd_pkg;
	localparam int COUNT_BITS = 24;
	localparam int BLOCK_BYTES = 18;
	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	typedef logic [4:0] pos_t;

	// exact fp16 -> fp32 widening, subnormals normalized
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0] ex;
		logic [9:0] man;
		logic [3:0] p;
		logic [31:0] r;
		ex = h[14:10];
		man = h[9:0];
		p = 4'd0;
		r = {h[15], 31'd0};
		for (int i = 0; i < 10; i++) begin
			if (man[i]) p = 4'(i);
		end
		if (ex == 5'd0) begin
			if (man != 10'd0) begin
				r = {h[15], 8'(p + 8'd103), 23'((32'(man) << (5'd23 - 5'(p))) & 32'h7F_FFFF)};
			end
		end else if (ex == 5'h1F) begin
			r = {h[15], 8'hFF, man, 13'd0};
		end else begin
			r = {h[15], 8'(ex + 8'd112), man, 13'd0};
		end
		return r;
	endfunction

	// exact (q-8)*scale; magnitude |q-8| <= 8 so at most 4 significant bits
	function automatic logic [31:0] scaled_weight(input logic [3:0] q, input logic [31:0] s);
		logic sgn, sq;
		logic [3:0] m;
		logic [7:0] se;
		logic [22:0] sm;
		logic [27:0] prod;
		logic [1:0] sh;
		logic [9:0] e;
		logic [23:0] sig;
		logic [31:0] r;
		sq = (q < 4'd8);
		m = sq ? 4'(4'd8 - q) : 4'(q - 4'd8);
		sgn = sq ^ s[31];
		se = s[30:23];
		sm = s[22:0];
		r = {sgn, 31'd0};
		if (se == 8'hFF) begin
			if (sm != 23'd0 || m == 4'd0) r = CANON_NAN;
			else r = {sgn, 8'hFF, 23'd0};
		end else if (se != 8'd0 && m != 4'd0) begin
			// leading one of the product sits at bit 23..26
			prod = 28'({1'b1, sm}) * 28'(m);
			if (prod[26]) sh = 2'd3;
			else if (prod[25]) sh = 2'd2;
			else if (prod[24]) sh = 2'd1;
			else sh = 2'd0;
			sig = 24'(prod >> sh);
			e = 10'(se) + 10'(sh);
			if (e >= 10'd255) r = {sgn, 8'hFF, 23'd0};
			else r = {sgn, e[7:0], sig[22:0]};
		end
		return r;
	endfunction
endpackage

>>> design/q4_block_dequantizer.sv
// q4_block_dequantizer: Q4_0 block decoder, one byte per unstalled cycle.
// Input channel in_valid/in_ready/in_byte carries 18-byte blocks: two bytes
// of little-endian fp16 scale, then 16 packed weight bytes.
// Output channel out_valid/out_ready carries one item per weight byte:
// weight_even (low nibble) and weight_odd (high nibble) as fp32 bits,
// block_last on the 16th pair, tensor_last when the block ends the tensor.
// Config channel cfg_valid/cfg_ready/cfg_data sets block_count (reset 1);
// write only when idle.
// out_valid rises in the cycle after an input accept. Throughput: one
// byte per cycle unless stalled; the only register between in and out is
// the output register, so a stalled receiver holds its item and in_ready
// drops only while it is full and not taken. Scale bytes give no item.
// Reset clears position, scale, block counter and the output valid;
// block_count returns to 1.
module q4_block_dequantizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] weight_even,
	output logic [31:0] weight_odd,
	output logic        block_last,
	output logic        tensor_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] cfg_data
);
	localparam int CB = q4bd_pkg::COUNT_BITS;

	logic [CB-1:0] block_count_q, blocks_done_q;
	q4bd_pkg::pos_t pos_q;
	logic [7:0] scale_lo_q;
	logic [31:0] scale_q;
	logic acc, is_w, blast, tlast;
	logic [CB:0] done_inc;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid || out_ready;
	assign acc = in_valid && in_ready;
	assign is_w = pos_q >= 5'd2;
	assign blast = pos_q == 5'(q4bd_pkg::BLOCK_BYTES - 1);
	assign done_inc = {1'b0, blocks_done_q} + 1'b1;
	assign tlast = blast && (done_inc >= {1'b0, block_count_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_count_q <= CB'(1);
			blocks_done_q <= '0;
			pos_q <= '0;
			scale_lo_q <= '0;
			scale_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) block_count_q <= CB'(cfg_data);
			if (acc && is_w) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (acc) begin
				if (pos_q == 5'd0) begin
					scale_lo_q <= in_byte;
					pos_q <= 5'd1;
				end else if (pos_q == 5'd1) begin
					scale_q <= q4bd_pkg::half_to_single({in_byte, scale_lo_q});
					pos_q <= 5'd2;
				end else begin
					if (blast) blocks_done_q <= tlast ? '0 : done_inc[CB-1:0];
					pos_q <= (blast || pos_q >= 5'(q4bd_pkg::BLOCK_BYTES)) ? 5'd0 : pos_q + 5'd1;
				end
			end
		end
	end

	// output payload, no reset
	always_ff @(posedge clk) begin
		if (acc && is_w) begin
			weight_even <= q4bd_pkg::scaled_weight(in_byte[3:0], scale_q);
			weight_odd <= q4bd_pkg::scaled_weight(in_byte[7:4], scale_q);
			block_last <= blast;
			tensor_last <= tlast;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(weight_even))
		else $error("stalled item changed");
	a_tl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tensor_last |-> block_last)
		else $error("tensor_last without block_last");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= 5'(q4bd_pkg::BLOCK_BYTES - 1))
		else $error("byte position out of range");
endmodule
